// File: rtl/core/vector_outline_list_decoder_top_defines.svh
// Assertion macros for the outline list decoder.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef VECTOR_OUTLINE_LIST_DECODER_TOP_DEFINES_SVH
`define VECTOR_OUTLINE_LIST_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define VOLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define VOLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VOLD_ASSERT_NOW(lbl, ante, cons, msg)
`define VOLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/vold_pkg.sv
// Shared types and constants for the outline list decoder.
// No dependencies.
package vold_pkg;

  localparam logic [7:0] MARK_BYTE   = 8'hFF;
  localparam logic [3:0] OLIVE_INDEX = 4'd8;

  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_PAINT = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_HDR_X   = 10'b00_0000_0010,
    PH_HDR_Y   = 10'b00_0000_0100,
    PH_START_X = 10'b00_0000_1000,
    PH_START_Y = 10'b00_0001_0000,
    PH_PT_X    = 10'b00_0010_0000,
    PH_PT_Y    = 10'b00_0100_0000,
    PH_FILL_X  = 10'b00_1000_0000,
    PH_FILL_Y  = 10'b01_0000_0000,
    PH_FILL_C  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       shadow_pass;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cmd_kind;
    logic [8:0] start_x;
    logic [8:0] start_y;
    logic [8:0] end_x;
    logic [8:0] end_y;
    logic [3:0] draw_color;
    logic [3:0] edge_color;
  } out_item_t;

  // A decoded command handed to the output buffer.
  typedef struct packed {
    logic      push;
    out_item_t item;
  } result_t;

endpackage

// File: rtl/core/vold_decode.sv
// Record decoding state and command generation for the outline list decoder.
// Depends on vold_pkg.
module vold_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  vold_pkg::in_item_t in_item,
  output vold_pkg::result_t  result
);

  vold_pkg::phase_t phase_r, phase_nxt;
  logic [6:0] origin_x_r, origin_x_nxt;
  logic [7:0] origin_y_r, origin_y_nxt;
  logic [3:0] border_r, border_nxt;
  logic [7:0] pen_x_r, pen_x_nxt;
  logic [7:0] pen_y_r, pen_y_nxt;
  logic [7:0] held_x_r, held_x_nxt;
  logic [7:0] held_y_r, held_y_nxt;
  logic       shadow_r, shadow_nxt;

  logic [7:0] b;
  assign b = in_item.data_byte;

  always_comb begin
    phase_nxt    = phase_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    border_nxt   = border_r;
    pen_x_nxt    = pen_x_r;
    pen_y_nxt    = pen_y_r;
    held_x_nxt   = held_x_r;
    held_y_nxt   = held_y_r;
    shadow_nxt   = shadow_r;
    result       = '0;
    if (accept) begin
      if (in_item.record_start) begin
        shadow_nxt = in_item.shadow_pass;
        border_nxt = in_item.shadow_pass ? vold_pkg::OLIVE_INDEX : {1'b0, b[2:0]};
        phase_nxt  = vold_pkg::PH_HDR_X;
      end else begin
        case (phase_r)
          vold_pkg::PH_HDR_X: begin
            origin_x_nxt = b[7:1];
            phase_nxt    = vold_pkg::PH_HDR_Y;
          end
          vold_pkg::PH_HDR_Y: begin
            origin_y_nxt = b;
            phase_nxt    = vold_pkg::PH_START_X;
          end
          vold_pkg::PH_START_X: begin
            pen_x_nxt = b;
            phase_nxt = vold_pkg::PH_START_Y;
          end
          vold_pkg::PH_START_Y: begin
            pen_y_nxt = b;
            phase_nxt = vold_pkg::PH_PT_X;
          end
          vold_pkg::PH_PT_X: begin
            held_x_nxt = b;
            phase_nxt  = vold_pkg::PH_PT_Y;
          end
          vold_pkg::PH_PT_Y: begin
            if (b == vold_pkg::MARK_BYTE) begin
              // Pen-up, or the end of the polyline when x was a mark too.
              phase_nxt = (held_x_r == vold_pkg::MARK_BYTE) ? vold_pkg::PH_FILL_X
                                                             : vold_pkg::PH_START_X;
            end else begin
              result.push            = 1'b1;
              result.item.cmd_kind   = vold_pkg::KIND_LINE;
              result.item.start_x    = {1'b0, pen_x_r} + {2'b00, origin_x_r};
              result.item.start_y    = {1'b0, pen_y_r} + {1'b0, origin_y_r};
              result.item.end_x      = {1'b0, held_x_r} + {2'b00, origin_x_r};
              result.item.end_y      = {1'b0, b} + {1'b0, origin_y_r};
              result.item.draw_color = border_r;
              pen_x_nxt              = held_x_r;
              pen_y_nxt              = b;
              phase_nxt              = vold_pkg::PH_PT_X;
            end
          end
          vold_pkg::PH_FILL_X: begin
            held_x_nxt = b;
            phase_nxt  = vold_pkg::PH_FILL_Y;
          end
          vold_pkg::PH_FILL_Y: begin
            held_y_nxt = b;
            if (held_x_r == vold_pkg::MARK_BYTE && b == vold_pkg::MARK_BYTE) begin
              result.push          = 1'b1;
              result.item.cmd_kind = vold_pkg::KIND_END;
              phase_nxt            = vold_pkg::PH_IDLE;
            end else begin
              phase_nxt = vold_pkg::PH_FILL_C;
            end
          end
          vold_pkg::PH_FILL_C: begin
            result.push            = 1'b1;
            result.item.cmd_kind   = vold_pkg::KIND_PAINT;
            result.item.start_x    = {1'b0, held_x_r} + {2'b00, origin_x_r};
            result.item.start_y    = {1'b0, held_y_r} + {1'b0, origin_y_r};
            result.item.draw_color = shadow_r ? vold_pkg::OLIVE_INDEX : {1'b0, b[2:0]};
            result.item.edge_color = border_r;
            phase_nxt              = vold_pkg::PH_FILL_X;
          end
          default: begin
            phase_nxt = vold_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= vold_pkg::PH_IDLE;
      origin_x_r <= '0;
      origin_y_r <= '0;
      border_r   <= '0;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      held_x_r   <= '0;
      held_y_r   <= '0;
      shadow_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      border_r   <= border_nxt;
      pen_x_r    <= pen_x_nxt;
      pen_y_r    <= pen_y_nxt;
      held_x_r   <= held_x_nxt;
      held_y_r   <= held_y_nxt;
      shadow_r   <= shadow_nxt;
    end
  end

endmodule

// File: rtl/core/vold_out_buf.sv
// Two-entry output register with skid slot for the outline list decoder.
// Depends on vold_pkg and the assertion macro header.
`include "vector_outline_list_decoder_top_defines.svh"
module vold_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  vold_pkg::result_t   result,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output vold_pkg::out_item_t out_item
);

  logic                main_vld_r;
  logic                skid_vld_r;
  vold_pkg::out_item_t main_r;
  vold_pkg::out_item_t skid_r;
  logic                pop;

  assign pop       = main_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_item  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= result.push;
      end else begin
        main_vld_r <= result.push;
      end
    end else if (!main_vld_r) begin
      main_vld_r <= result.push;
    end else if (result.push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
        skid_r <= result.item;
      end else begin
        main_r <= result.item;
      end
    end else if (!main_vld_r) begin
      main_r <= result.item;
    end else if (result.push) begin
      skid_r <= result.item;
    end
  end

  `VOLD_ASSERT_NOW(a_skid_behind_main, skid_vld_r, main_vld_r, "skid holds an item ahead of main")
  `VOLD_ASSERT_NOW(a_no_push_when_full, result.push, !skid_vld_r, "result pushed into full buffer")
  `VOLD_ASSERT_NEXT(a_stalled_item_kept, main_vld_r && out_stall, main_vld_r, "stalled item lost")

endmodule

// File: rtl/core/vector_outline_list_decoder_top.sv
// Outline list decoder: one record byte per item in, at most one drawing command out.
// Throughput is one item per cycle while in_stall is low; commands leave from a register.
// The decode state machine and its coordinate adders form each command combinationally.
// in_stall rises only when both output slots hold commands that have not been taken.
// rst_n is synchronous and active low; it returns the decoder to idle, awaiting a record.
module vector_outline_list_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vold_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output vold_pkg::out_item_t out_item
);

  // An item is taken whenever the skid slot of the output buffer is free. Because the
  // stall comes straight from a register, the upstream side sees no path through the
  // decoder, and a byte can arrive while a finished command still waits downstream.
  logic              accept;
  logic              buf_full;
  vold_pkg::result_t result;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Phase tracking, header offsets, pen position and the command generation for the
  // line, paint and end cases all live here. A start-of-record byte always restarts
  // decoding, even in the middle of a record.
  vold_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .result  (result)
  );

  // The result register and its skid slot: commands leave in the order they were made.
  vold_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
